FILE: design/stt_pkg.sv
`default_nettype none
package stt_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LINE_BITS = 16;
	localparam int COLUMN_BITS = 16;
	localparam int MAX_KEYWORD_LEN = 9;
	localparam int KW_COUNT = 28;
	localparam int PREFIX_BITS = 8 * MAX_KEYWORD_LEN;
	localparam int WLEN_BITS = $clog2(MAX_KEYWORD_LEN + 2);

	localparam logic [6:0] K_IDENT = 7'd0;
	localparam logic [6:0] K_NUMBER = 7'd1;
	localparam logic [6:0] K_STRING = 7'd2;
	localparam logic [6:0] K_CHAR = 7'd3;
	localparam logic [6:0] K_KW0 = 7'd4;
	localparam logic [6:0] K_PLUS = 7'd32;
	localparam logic [6:0] K_MINUS = 7'd33;
	localparam logic [6:0] K_ARROW = 7'd34;
	localparam logic [6:0] K_STAR = 7'd35;
	localparam logic [6:0] K_SLASH = 7'd36;
	localparam logic [6:0] K_DSLASH = 7'd37;
	localparam logic [6:0] K_PERCENT = 7'd38;
	localparam logic [6:0] K_CARET = 7'd39;
	localparam logic [6:0] K_CARET_EQ = 7'd40;
	localparam logic [6:0] K_HASH = 7'd41;
	localparam logic [6:0] K_BAR_EQ = 7'd42;
	localparam logic [6:0] K_BAR = 7'd43;
	localparam logic [6:0] K_QUESTION = 7'd44;
	localparam logic [6:0] K_EQ = 7'd45;
	localparam logic [6:0] K_ASSIGN = 7'd46;
	localparam logic [6:0] K_TILDE = 7'd47;
	localparam logic [6:0] K_NE = 7'd48;
	localparam logic [6:0] K_SHL = 7'd49;
	localparam logic [6:0] K_LE = 7'd50;
	localparam logic [6:0] K_LT = 7'd51;
	localparam logic [6:0] K_GE = 7'd52;
	localparam logic [6:0] K_GT = 7'd53;
	localparam logic [6:0] K_AMP = 7'd54;
	localparam logic [6:0] K_DOTDOT = 7'd55;
	localparam logic [6:0] K_DOT = 7'd56;
	localparam logic [6:0] K_LPAREN = 7'd57;
	localparam logic [6:0] K_RPAREN = 7'd58;
	localparam logic [6:0] K_LBRACE = 7'd59;
	localparam logic [6:0] K_RBRACE = 7'd60;
	localparam logic [6:0] K_LBRACK = 7'd61;
	localparam logic [6:0] K_RBRACK = 7'd62;
	localparam logic [6:0] K_COMMA = 7'd63;
	localparam logic [6:0] K_SEMI = 7'd64;
	localparam logic [6:0] K_DCOLON = 7'd65;
	localparam logic [6:0] K_COLON = 7'd66;
	localparam logic [6:0] K_END = 7'd67;
	localparam logic [6:0] K_ERROR = 7'd68;

	localparam logic [2:0] E_NONE = 3'd0;
	localparam logic [2:0] E_NEWLINE = 3'd1;
	localparam logic [2:0] E_UNTERM = 3'd2;
	localparam logic [2:0] E_BADCHAR = 3'd3;
	localparam logic [2:0] E_BANG = 3'd4;
	localparam logic [2:0] E_UNEXPECTED = 3'd5;

	localparam logic [PREFIX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		PREFIX_BITS'("MUTABLE"), PREFIX_BITS'("CONST"), PREFIX_BITS'("Array"),
		PREFIX_BITS'("Boolean"), PREFIX_BITS'("true"), PREFIX_BITS'("false"),
		PREFIX_BITS'("if"), PREFIX_BITS'("in"), PREFIX_BITS'("and"),
		PREFIX_BITS'("or"), PREFIX_BITS'("not"), PREFIX_BITS'("then"),
		PREFIX_BITS'("else"), PREFIX_BITS'("elseif"), PREFIX_BITS'("for"),
		PREFIX_BITS'("do"), PREFIX_BITS'("method"), PREFIX_BITS'("procedure"),
		PREFIX_BITS'("function"), PREFIX_BITS'("begin"), PREFIX_BITS'("end"),
		PREFIX_BITS'("is"), PREFIX_BITS'("return"), PREFIX_BITS'("while"),
		PREFIX_BITS'("repeat"), PREFIX_BITS'("until"), PREFIX_BITS'("break"),
		PREFIX_BITS'("continue")
	};
	localparam int KW_LEN [KW_COUNT] = '{
		7, 5, 5, 7, 4, 5, 2, 2, 3, 2, 3, 4, 4, 6, 3, 2, 6, 9, 8, 5, 3, 2, 6, 5,
		6, 5, 5, 8
	};

	typedef struct packed {
		logic [6:0]             kind;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] len;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [7:0]             cval;
		logic [2:0]             err;
		logic                   last;
	} res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_";
	endfunction

	// Word text is right aligned: the newest byte sits in the low byte.
	function automatic logic [6:0] kw_kind(input logic [PREFIX_BITS-1:0] w,
			input logic [WLEN_BITS-1:0] n);
		logic [6:0] k;
		logic [PREFIX_BITS-1:0] m;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			m = (PREFIX_BITS'(1) << (8 * KW_LEN[i])) - PREFIX_BITS'(1);
			if (n == WLEN_BITS'(KW_LEN[i]) && (w & m) == KW_TEXT[i])
				k = K_KW0 + 7'(i);
		end
		return k;
	endfunction

endpackage
`default_nettype wire

FILE: design/stt_res_fifo.sv
`default_nettype none
module stt_res_fifo
	import stt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire  [1:0] push_cnt,
	input  res_t       push_data [3],
	input  wire        pop,
	output res_t       head,
	output logic [2:0] count
);

	res_t       mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + push_cnt;
			rd_q <= rd_q + 2'(pop);
			count_q <= count_q + 3'(push_cnt) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			if (2'(i) < push_cnt)
				mem_q[wr_q + 2'(i)] <= push_data[i];
	end

	assign head = mem_q[rd_q];
	assign count = count_q;

endmodule
`default_nettype wire

FILE: design/source_text_tokenizer_core.sv
// A token is written to the result queue when the byte that completes it is taken.
// Throughput: one byte per cycle while each byte yields at most one result and
// results are drained at one per cycle; a byte that yields two or three results
// holds off the next byte while the four-entry result queue drains.
// Reset (arst_n low, asynchronous): scanner idle, offset 0, line and column 1,
// result queue empty.
`default_nettype none
module source_text_tokenizer_core
	import stt_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire  [7:0]             src_byte,
	input  wire                    end_of_text,
	input  wire                    in_valid,
	output logic                   in_ready,
	output logic [6:0]             token_kind,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [OFFSET_BITS-1:0] token_length,
	output logic [LINE_BITS-1:0]   line_number,
	output logic [COLUMN_BITS-1:0] column_number,
	output logic [7:0]             char_value,
	output logic [2:0]             error_code,
	output logic                   last,
	output logic                   out_valid,
	input  wire                    out_ready
);

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_IDENT, M_NUMI, M_NUMF, M_DOT, M_STR, M_STRESC,
		M_CHQ, M_CHV, M_PEND, M_DONE
	} mode_t;

	mode_t                   mode_q, mode_d;
	logic [7:0]              held_q, held_d;
	logic [PREFIX_BITS-1:0]  prefix_q, prefix_d;
	logic [WLEN_BITS-1:0]    wlen_q, wlen_d;
	logic [OFFSET_BITS-1:0]  tstart_q, tstart_d;
	logic [LINE_BITS-1:0]    tline_q, tline_d;
	logic [COLUMN_BITS-1:0]  tcol_q, tcol_d;
	logic [OFFSET_BITS-1:0]  off_q, off_d;
	logic [LINE_BITS-1:0]    line_q, line_d;
	logic [COLUMN_BITS-1:0]  col_q, col_d;
	logic [7:0]              lit_q, lit_d;

	res_t       res [3];
	logic [1:0] nres;
	logic [1:0] push_cnt;
	logic       accept;
	res_t       head;
	logic [2:0] count;

	function automatic res_t mk(input logic [6:0] k, input logic [OFFSET_BITS-1:0] s,
			input logic [OFFSET_BITS-1:0] l, input logic [LINE_BITS-1:0] ln,
			input logic [COLUMN_BITS-1:0] cl, input logic [7:0] cv,
			input logic [2:0] e, input logic lst);
		res_t r;
		r.kind = k;
		r.start = s;
		r.len = l;
		r.line = ln;
		r.col = cl;
		r.cval = cv;
		r.err = e;
		r.last = lst;
		return r;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] e,
			input logic [OFFSET_BITS-1:0] s);
		return (e >= s) ? e - s : '0;
	endfunction

	// Room for the worst case of three results per byte.
	assign in_ready = (count <= 3'd1);
	assign accept = in_valid && in_ready;
	assign push_cnt = accept ? nres : 2'd0;

	always_comb begin
		logic [7:0] c;
		logic [OFFSET_BITS-1:0] next_off;
		logic fresh, fail, consumed, two;
		logic [6:0] k;
		c = src_byte;
		next_off = (&off_q) ? off_q : off_q + 1'b1;
		fresh = 1'b0;
		fail = 1'b0;
		consumed = 1'b1;
		two = 1'b0;
		k = K_ERROR;
		nres = 2'd0;
		res[0] = '0;
		res[1] = '0;
		res[2] = '0;
		mode_d = mode_q;
		held_d = held_q;
		prefix_d = prefix_q;
		wlen_d = wlen_q;
		tstart_d = tstart_q;
		tline_d = tline_q;
		tcol_d = tcol_q;
		off_d = off_q;
		line_d = line_q;
		col_d = col_q;
		lit_d = lit_q;

		if (mode_q == M_DONE) begin
			// Drop every beat until reset.
		end else if (end_of_text) begin
			// Flush the open token, then close the stream.
			case (mode_q)
				M_IDENT: begin
					res[nres] = mk(kw_kind(prefix_q, wlen_q), tstart_q,
						span(off_q, tstart_q), tline_q, tcol_q, 8'd0, E_NONE, 1'b0);
					nres = nres + 2'd1;
				end
				M_NUMI, M_NUMF: begin
					res[nres] = mk(K_NUMBER, tstart_q, span(off_q, tstart_q),
						tline_q, tcol_q, 8'd0, E_NONE, 1'b0);
					nres = nres + 2'd1;
				end
				M_DOT: begin
					res[nres] = mk(K_DOT, tstart_q, OFFSET_BITS'(1), tline_q, tcol_q,
						8'd0, E_NONE, 1'b0);
					nres = nres + 2'd1;
				end
				M_STR, M_STRESC: begin
					res[nres] = mk(K_STRING, tstart_q, span(off_q, tstart_q),
						tline_q, tcol_q, 8'd0, E_UNTERM, 1'b0);
					nres = nres + 2'd1;
				end
				M_CHQ, M_CHV: begin
					res[nres] = mk(K_CHAR, tstart_q, span(off_q, tstart_q),
						tline_q, tcol_q, lit_q, E_BADCHAR, 1'b0);
					nres = nres + 2'd1;
				end
				M_PEND: begin
					case (held_q)
						"-": k = K_MINUS;
						"/": k = K_SLASH;
						"^": k = K_CARET;
						"|": k = K_BAR;
						"=": k = K_ASSIGN;
						"<": k = K_LT;
						">": k = K_GT;
						":": k = K_COLON;
						default: k = K_ERROR;
					endcase
					res[nres] = mk(k, tstart_q, OFFSET_BITS'(1), tline_q, tcol_q, 8'd0,
						(k == K_ERROR) ? E_BANG : E_NONE, 1'b0);
					nres = nres + 2'd1;
				end
				default: ;
			endcase
			res[nres] = mk(K_END, off_q, '0, line_q, col_q, 8'd0, E_NONE, 1'b1);
			nres = nres + 2'd1;
			mode_d = M_DONE;
		end else begin
			fresh = (mode_q == M_IDLE);
			case (mode_q)
				M_COMMENT: if (c == "\n") mode_d = M_IDLE;
				M_IDENT: begin
					if (is_word(c)) begin
						if (wlen_q < WLEN_BITS'(MAX_KEYWORD_LEN))
							prefix_d = {prefix_q[PREFIX_BITS-9:0], c};
						if (wlen_q <= WLEN_BITS'(MAX_KEYWORD_LEN))
							wlen_d = wlen_q + 1'b1;
					end else begin
						res[nres] = mk(kw_kind(prefix_q, wlen_q), tstart_q,
							span(off_q, tstart_q), tline_q, tcol_q, 8'd0, E_NONE, 1'b0);
						nres = nres + 2'd1;
						mode_d = M_IDLE;
						fresh = 1'b1;
					end
				end
				M_NUMI, M_NUMF: begin
					if (mode_q == M_NUMI && c == ".") begin
						mode_d = M_NUMF;
					end else if (!is_digit(c)) begin
						res[nres] = mk(K_NUMBER, tstart_q, span(off_q, tstart_q),
							tline_q, tcol_q, 8'd0, E_NONE, 1'b0);
						nres = nres + 2'd1;
						mode_d = M_IDLE;
						fresh = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(c)) begin
						mode_d = M_NUMI;
					end else if (c == ".") begin
						res[nres] = mk(K_DOTDOT, tstart_q, span(next_off, tstart_q),
							tline_q, tcol_q, 8'd0, E_NONE, 1'b0);
						nres = nres + 2'd1;
						mode_d = M_IDLE;
					end else begin
						res[nres] = mk(K_DOT, tstart_q, OFFSET_BITS'(1), tline_q, tcol_q,
							8'd0, E_NONE, 1'b0);
						nres = nres + 2'd1;
						mode_d = M_IDLE;
						fresh = 1'b1;
					end
				end
				M_STR: begin
					if (c == "\"") begin
						res[nres] = mk(K_STRING, tstart_q, span(off_q, tstart_q),
							tline_q, tcol_q, 8'd0, E_NONE, 1'b0);
						nres = nres + 2'd1;
						mode_d = M_IDLE;
					end else if (c == "\n") begin
						res[nres] = mk(K_STRING, tstart_q, span(off_q, tstart_q),
							tline_q, tcol_q, 8'd0, E_NEWLINE, 1'b0);
						nres = nres + 2'd1;
						fail = 1'b1;
					end else if (c == "\\") begin
						mode_d = M_STRESC;
					end
				end
				M_STRESC: mode_d = M_STR;
				M_CHQ: begin
					lit_d = c;
					mode_d = M_CHV;
				end
				M_CHV: begin
					res[nres] = mk(K_CHAR, tstart_q, span(next_off, tstart_q),
						tline_q, tcol_q, lit_q, (c == "'") ? E_NONE : E_BADCHAR, 1'b0);
					nres = nres + 2'd1;
					if (c == "'") mode_d = M_IDLE;
					else fail = 1'b1;
				end
				M_PEND: begin
					if (held_q == "-" && c == "-") begin
						mode_d = M_COMMENT;
					end else begin
						two = 1'b1;
						case (held_q)
							"-": k = (c == ">") ? K_ARROW : K_MINUS;
							"/": k = (c == "/") ? K_DSLASH : K_SLASH;
							"^": k = (c == "=") ? K_CARET_EQ : K_CARET;
							"|": k = (c == "=") ? K_BAR_EQ : K_BAR;
							"=": k = (c == "=") ? K_EQ : K_ASSIGN;
							"!": k = (c == "=") ? K_NE : K_ERROR;
							"<": k = (c == "<") ? K_SHL : (c == "=") ? K_LE : K_LT;
							">": k = (c == "=") ? K_GE : K_GT;
							":": k = (c == "=") ? K_ASSIGN : (c == ":") ? K_DCOLON : K_COLON;
							default: k = K_ERROR;
						endcase
						two = (held_q == "<" || held_q == ":") ? (c == "=" || c == held_q)
							: (held_q == "-") ? (c == ">")
							: (held_q == "/") ? (c == "/")
							: (held_q == "^" || held_q == "|" || held_q == "=" ||
								held_q == "!" || held_q == ">") ? (c == "=") : 1'b0;
						if (k == K_ERROR) begin
							res[nres] = mk(K_ERROR, tstart_q, OFFSET_BITS'(1), tline_q,
								tcol_q, 8'd0, E_BANG, 1'b0);
							nres = nres + 2'd1;
							fail = 1'b1;
							consumed = 1'b0;
						end else if (two) begin
							res[nres] = mk(k, tstart_q, span(next_off, tstart_q), tline_q,
								tcol_q, 8'd0, E_NONE, 1'b0);
							nres = nres + 2'd1;
							mode_d = M_IDLE;
						end else begin
							res[nres] = mk(k, tstart_q, OFFSET_BITS'(1), tline_q, tcol_q,
								8'd0, E_NONE, 1'b0);
							nres = nres + 2'd1;
							mode_d = M_IDLE;
							fresh = 1'b1;
						end
					end
				end
				default: ;
			endcase

			// Open a new token on this byte.
			if (fresh && !fail && !(c == " " || c == "\t" || c == "\r" || c == "\n")) begin
				tstart_d = off_q;
				tline_d = line_q;
				tcol_d = col_q;
				if (is_alpha(c) || c == "_") begin
					prefix_d = {prefix_q[PREFIX_BITS-9:0], c};
					wlen_d = WLEN_BITS'(1);
					mode_d = M_IDENT;
				end else if (is_digit(c)) begin
					mode_d = M_NUMI;
				end else if (c == ".") begin
					mode_d = M_DOT;
				end else if (c == "\"") begin
					tstart_d = next_off;
					mode_d = M_STR;
				end else if (c == "'") begin
					lit_d = 8'd0;
					mode_d = M_CHQ;
				end else if (c == "-" || c == "/" || c == "^" || c == "|" || c == "=" ||
						c == "!" || c == "<" || c == ">" || c == ":") begin
					held_d = c;
					mode_d = M_PEND;
				end else begin
					case (c)
						"+": k = K_PLUS;
						"*": k = K_STAR;
						"%": k = K_PERCENT;
						"#": k = K_HASH;
						"?": k = K_QUESTION;
						"~": k = K_TILDE;
						"&": k = K_AMP;
						"(": k = K_LPAREN;
						")": k = K_RPAREN;
						"{": k = K_LBRACE;
						"}": k = K_RBRACE;
						"[": k = K_LBRACK;
						"]": k = K_RBRACK;
						",": k = K_COMMA;
						";": k = K_SEMI;
						default: k = K_ERROR;
					endcase
					res[nres] = mk(k, off_q, OFFSET_BITS'(1), line_q, col_q, 8'd0,
						(k == K_ERROR) ? E_UNEXPECTED : E_NONE, 1'b0);
					nres = nres + 2'd1;
					fail = (k == K_ERROR);
				end
			end

			// Advance position; line and column saturate.
			if (consumed) begin
				off_d = next_off;
				if (c == "\n") begin
					line_d = (&line_q) ? line_q : line_q + 1'b1;
					col_d = COLUMN_BITS'(1);
				end else begin
					col_d = (&col_q) ? col_q : col_q + 1'b1;
				end
			end
			if (fail) begin
				mode_d = M_DONE;
				res[nres] = mk(K_END, off_d, '0, line_d, col_d, 8'd0, E_NONE, 1'b1);
				nres = nres + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			held_q <= '0;
			wlen_q <= '0;
			tstart_q <= '0;
			tline_q <= LINE_BITS'(1);
			tcol_q <= COLUMN_BITS'(1);
			off_q <= '0;
			line_q <= LINE_BITS'(1);
			col_q <= COLUMN_BITS'(1);
			lit_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
			wlen_q <= wlen_d;
			tstart_q <= tstart_d;
			tline_q <= tline_d;
			tcol_q <= tcol_d;
			off_q <= off_d;
			line_q <= line_d;
			col_q <= col_d;
			lit_q <= lit_d;
		end
	end

	// Word text needs no reset: only bytes of the current word are compared.
	always_ff @(posedge clk) begin
		if (accept)
			prefix_q <= prefix_d;
	end

	stt_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_data (res),
		.pop       (out_valid && out_ready),
		.head      (head),
		.count     (count)
	);

	assign out_valid = (count != 3'd0);
	assign token_kind = head.kind;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign line_number = head.line;
	assign column_number = head.col;
	assign char_value = head.cval;
	assign error_code = head.err;
	assign last = head.last;

endmodule
`default_nettype wire

FILE: test/testbench.sv
module testbench
	import stt_pkg::*;
();

	typedef enum logic [3:0] {
		SCAN_IDLE, SCAN_COMMENT, SCAN_WORD, SCAN_INT, SCAN_FRAC, SCAN_DOT,
		SCAN_STR, SCAN_ESC, SCAN_CHQ, SCAN_CHV, SCAN_OP, SCAN_DONE
	} scan_t;

	localparam int LIMIT = 20000;
	localparam logic [OFFSET_BITS-1:0] OFF_TOP = '1;
	localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
	localparam logic [COLUMN_BITS-1:0] COL_TOP = '1;

	// Keyword spellings in kind order, starting at K_KW0.
	string kw_words [KW_COUNT] = '{
		"MUTABLE", "CONST", "Array", "Boolean", "true", "false", "if", "in",
		"and", "or", "not", "then", "else", "elseif", "for", "do", "method",
		"procedure", "function", "begin", "end", "is", "return", "while",
		"repeat", "until", "break", "continue"
	};
	// Legal operator spellings; a lone bang is kept for the final error.
	string op_words [35] = '{
		"+", "-", "->", "*", "/", "//", "%", "^", "^=", "#", "|=", "|", "?",
		"==", "=", ":=", "~", "!=", "<<", "<=", "<", ">=", ">", "&", "..", ".",
		"(", ")", "{", "}", "[", "]", ",", ";", "::"
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [7:0] src_byte = 8'd0;
	logic end_of_text = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [6:0] token_kind;
	logic [OFFSET_BITS-1:0] start_offset;
	logic [OFFSET_BITS-1:0] token_length;
	logic [LINE_BITS-1:0] line_number;
	logic [COLUMN_BITS-1:0] column_number;
	logic [7:0] char_value;
	logic [2:0] error_code;
	logic last;
	logic out_valid;
	logic out_ready = 1'b0;

	source_text_tokenizer_core dut (
		.clk(clk), .arst_n(arst_n),
		.src_byte(src_byte), .end_of_text(end_of_text),
		.in_valid(in_valid), .in_ready(in_ready),
		.token_kind(token_kind), .start_offset(start_offset),
		.token_length(token_length), .line_number(line_number),
		.column_number(column_number), .char_value(char_value),
		.error_code(error_code), .last(last),
		.out_valid(out_valid), .out_ready(out_ready)
	);

	always #1 clk = ~clk;

	// Traffic shaping knobs, changed between phases.
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	int cycle_count = 0;
	int bytes_sent = 0;
	int tokens_seen = 0;
	int mismatches = 0;

	// Expected tokens, oldest first.
	res_t token_q [$];

	// Lexer shadow state.
	scan_t mode;
	logic [7:0] held;
	logic [7:0] word [MAX_KEYWORD_LEN];
	int wlen;
	logic [OFFSET_BITS-1:0] tstart, off;
	logic [LINE_BITS-1:0] tline, line;
	logic [COLUMN_BITS-1:0] tcol, col;
	logic [7:0] lit;

	initial begin
		mode = SCAN_IDLE;
		held = 8'd0;
		wlen = 0;
		tstart = '0;
		off = '0;
		tline = LINE_BITS'(1);
		line = LINE_BITS'(1);
		tcol = COLUMN_BITS'(1);
		col = COLUMN_BITS'(1);
		lit = 8'd0;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens still expected",
				cycle_count, token_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stalls per phase, plus a long hold-off when asked.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare every accepted beat against the oldest expected token.
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{token_kind, start_offset, token_length, line_number,
				column_number, char_value, error_code, last};
			tokens_seen++;
			if (token_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token kind=%0d start=%0d len=%0d",
						got.kind, got.start, got.len);
			end else begin
				want = token_q.pop_front();
				if (got.kind !== want.kind || got.start !== want.start ||
						got.len !== want.len || got.line !== want.line ||
						got.col !== want.col || got.cval !== want.cval ||
						got.err !== want.err || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"token mismatch: expected kind=%0d start=%0d len=%0d ",
							"line=%0d col=%0d cval=%0d err=%0d last=%0d, got kind=%0d ",
							"start=%0d len=%0d line=%0d col=%0d cval=%0d err=%0d last=%0d"},
							want.kind, want.start, want.len, want.line, want.col,
							want.cval, want.err, want.last, got.kind, got.start, got.len,
							got.line, got.col, got.cval, got.err, got.last);
				end
			end
		end
	end

	function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] e);
		return e >= tstart ? e - tstart : '0;
	endfunction

	task automatic push_tok(input logic [6:0] k, input logic [OFFSET_BITS-1:0] n,
			input logic [7:0] cv, input logic [2:0] ec);
		token_q.push_back('{k, tstart, n, tline, tcol, cv, ec, 1'b0});
	endtask

	task automatic push_end();
		token_q.push_back('{K_END, off, '0, line, col, 8'd0, E_NONE, 1'b1});
	endtask

	function automatic logic [6:0] word_kind();
		bit hit;
		for (int i = 0; i < KW_COUNT; i++) begin
			hit = (wlen == kw_words[i].len());
			for (int j = 0; j < kw_words[i].len() && hit; j++)
				if (word[j] != kw_words[i][j]) hit = 0;
			if (hit) return K_KW0 + 7'(i);
		end
		return K_IDENT;
	endfunction

	// Kind of a held operator byte h followed by c; two says c joins it.
	function automatic logic [6:0] pair_kind(input logic [7:0] h, input logic [7:0] c,
			output bit two);
		two = 1;
		case (h)
			"-": if (c == ">") return K_ARROW;
			"/": if (c == "/") return K_DSLASH;
			"^": if (c == "=") return K_CARET_EQ;
			"|": if (c == "=") return K_BAR_EQ;
			"=": if (c == "=") return K_EQ;
			"!": if (c == "=") return K_NE;
			"<": begin
				if (c == "<") return K_SHL;
				if (c == "=") return K_LE;
			end
			">": if (c == "=") return K_GE;
			":": begin
				if (c == "=") return K_ASSIGN;
				if (c == ":") return K_DCOLON;
			end
			default: ;
		endcase
		two = 0;
		case (h)
			"-": return K_MINUS;
			"/": return K_SLASH;
			"^": return K_CARET;
			"|": return K_BAR;
			"=": return K_ASSIGN;
			"<": return K_LT;
			">": return K_GT;
			":": return K_COLON;
			default: return K_ERROR;
		endcase
	endfunction

	function automatic logic [6:0] single_kind(input logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"*": return K_STAR;
			"%": return K_PERCENT;
			"#": return K_HASH;
			"?": return K_QUESTION;
			"~": return K_TILDE;
			"&": return K_AMP;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			"[": return K_LBRACK;
			"]": return K_RBRACK;
			",": return K_COMMA;
			";": return K_SEMI;
			default: return K_ERROR;
		endcase
	endfunction

	task automatic begin_token(input logic [7:0] c, output bit fail);
		logic [6:0] k;
		fail = 0;
		if (c == " " || c == 8'd9 || c == 8'd13 || c == 8'd10) return;
		tstart = off;
		tline = line;
		tcol = col;
		if (is_alpha(c) || c == "_") begin
			word[0] = c;
			wlen = 1;
			mode = SCAN_WORD;
		end else if (is_digit(c)) begin
			mode = SCAN_INT;
		end else if (c == ".") begin
			mode = SCAN_DOT;
		end else if (c == "\"") begin
			tstart = (off == OFF_TOP) ? off : off + 1'b1;
			mode = SCAN_STR;
		end else if (c == "'") begin
			lit = 8'd0;
			mode = SCAN_CHQ;
		end else if (c == "-" || c == "/" || c == "^" || c == "|" || c == "=" ||
				c == "!" || c == "<" || c == ">" || c == ":") begin
			held = c;
			mode = SCAN_OP;
		end else begin
			k = single_kind(c);
			push_tok(k, OFFSET_BITS'(1), 8'd0, k == K_ERROR ? E_UNEXPECTED : E_NONE);
			fail = (k == K_ERROR);
		end
	endtask

	// Advance the shadow lexer by one accepted beat.
	task automatic lex_beat(input logic [7:0] c, input bit eot);
		bit fresh, fail, used, two;
		logic [OFFSET_BITS-1:0] nxt;
		logic [6:0] k;
		fail = 0;
		used = 1;
		nxt = (off == OFF_TOP) ? off : off + 1'b1;
		if (mode == SCAN_DONE) return;
		if (eot) begin
			case (mode)
				SCAN_WORD: push_tok(word_kind(), span(off), 8'd0, E_NONE);
				SCAN_INT, SCAN_FRAC: push_tok(K_NUMBER, span(off), 8'd0, E_NONE);
				SCAN_DOT: push_tok(K_DOT, OFFSET_BITS'(1), 8'd0, E_NONE);
				SCAN_STR, SCAN_ESC: push_tok(K_STRING, span(off), 8'd0, E_UNTERM);
				SCAN_CHQ, SCAN_CHV: push_tok(K_CHAR, span(off), lit, E_BADCHAR);
				SCAN_OP: begin
					k = pair_kind(held, 8'd0, two);
					push_tok(k, OFFSET_BITS'(1), 8'd0, k == K_ERROR ? E_BANG : E_NONE);
				end
				default: ;
			endcase
			push_end();
			mode = SCAN_DONE;
			return;
		end
		fresh = (mode == SCAN_IDLE);
		case (mode)
			SCAN_COMMENT: if (c == 8'd10) mode = SCAN_IDLE;
			SCAN_WORD: begin
				if (is_word(c)) begin
					if (wlen < MAX_KEYWORD_LEN) word[wlen] = c;
					if (wlen <= MAX_KEYWORD_LEN) wlen++;
				end else begin
					push_tok(word_kind(), span(off), 8'd0, E_NONE);
					mode = SCAN_IDLE;
					fresh = 1;
				end
			end
			SCAN_INT: begin
				if (c == ".") mode = SCAN_FRAC;
				else if (!is_digit(c)) begin
					push_tok(K_NUMBER, span(off), 8'd0, E_NONE);
					mode = SCAN_IDLE;
					fresh = 1;
				end
			end
			SCAN_FRAC: begin
				if (!is_digit(c)) begin
					push_tok(K_NUMBER, span(off), 8'd0, E_NONE);
					mode = SCAN_IDLE;
					fresh = 1;
				end
			end
			SCAN_DOT: begin
				if (is_digit(c)) mode = SCAN_INT;
				else if (c == ".") begin
					push_tok(K_DOTDOT, span(nxt), 8'd0, E_NONE);
					mode = SCAN_IDLE;
				end else begin
					push_tok(K_DOT, OFFSET_BITS'(1), 8'd0, E_NONE);
					mode = SCAN_IDLE;
					fresh = 1;
				end
			end
			SCAN_STR: begin
				if (c == "\"") begin
					push_tok(K_STRING, span(off), 8'd0, E_NONE);
					mode = SCAN_IDLE;
				end else if (c == 8'd10) begin
					push_tok(K_STRING, span(off), 8'd0, E_NEWLINE);
					fail = 1;
				end else if (c == "\\") mode = SCAN_ESC;
			end
			SCAN_ESC: mode = SCAN_STR;
			SCAN_CHQ: begin
				lit = c;
				mode = SCAN_CHV;
			end
			SCAN_CHV: begin
				if (c == "'") begin
					push_tok(K_CHAR, span(nxt), lit, E_NONE);
					mode = SCAN_IDLE;
				end else begin
					push_tok(K_CHAR, span(nxt), lit, E_BADCHAR);
					fail = 1;
				end
			end
			SCAN_OP: begin
				if (held == "-" && c == "-") mode = SCAN_COMMENT;
				else begin
					k = pair_kind(held, c, two);
					if (k == K_ERROR) begin
						push_tok(K_ERROR, OFFSET_BITS'(1), 8'd0, E_BANG);
						fail = 1;
						used = 0;
					end else if (two) begin
						push_tok(k, span(nxt), 8'd0, E_NONE);
						mode = SCAN_IDLE;
					end else begin
						push_tok(k, OFFSET_BITS'(1), 8'd0, E_NONE);
						mode = SCAN_IDLE;
						fresh = 1;
					end
				end
			end
			default: ;
		endcase
		if (fresh && !fail) begin_token(c, fail);
		if (used) begin
			off = nxt;
			if (c == 8'd10) begin
				line = (line == LINE_TOP) ? line : line + 1'b1;
				col = COLUMN_BITS'(1);
			end else begin
				col = (col == COL_TOP) ? col : col + 1'b1;
			end
		end
		if (fail) begin
			mode = SCAN_DONE;
			push_end();
		end
	endtask

	// Offer one beat, hold it until taken, then update the shadow lexer.
	task automatic send_beat(input logic [7:0] c, input bit eot = 1'b0);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		src_byte <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		lex_beat(c, eot);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(s[i]);
	endtask

	// Emit one random well-formed lexeme (or a blank) into the stream.
	task automatic send_lexeme();
		int n;
		logic [7:0] b;
		case ($urandom_range(9))
			0: begin
				n = $urandom_range(12, 1);
				b = $urandom_range(1) ? 8'("_") : 8'($urandom_range("z", "a"));
				send_beat(b);
				for (int i = 1; i < n; i++) begin
					case ($urandom_range(3))
						0: b = 8'($urandom_range("Z", "A"));
						1: b = 8'($urandom_range("9", "0"));
						2: b = "_";
						default: b = 8'($urandom_range("z", "a"));
					endcase
					send_beat(b);
				end
			end
			1: send_text(kw_words[$urandom_range(KW_COUNT - 1)]);
			2: begin
				case ($urandom_range(3))
					0: send_beat(8'($urandom_range("9", "0")));
					1: send_text($sformatf("%0d.%0d", $urandom_range(9999), $urandom_range(99)));
					2: send_text($sformatf(".%0d", $urandom_range(999)));
					default: send_text($sformatf("%0d.", $urandom_range(99999)));
				endcase
			end
			3: begin
				send_beat("\"");
				n = $urandom_range(8);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(4) == 0) begin
						// escape: the next byte is taken raw, even a quote or newline
						send_beat("\\");
						send_beat(8'($urandom_range(255)));
					end else begin
						do b = 8'($urandom_range(126, 32)); while (b == "\"" || b == "\\");
						send_beat(b);
					end
				end
				send_beat("\"");
			end
			4: begin
				send_beat("'");
				send_beat(8'($urandom_range(255)));
				send_beat("'");
			end
			5: send_text(op_words[$urandom_range(34)]);
			6: begin
				case ($urandom_range(3))
					0: send_beat(8'd9);
					1: send_beat(8'd13);
					default: send_beat(" ");
				endcase
			end
			7: begin
				send_text("--");
				n = $urandom_range(6);
				for (int i = 0; i < n; i++) begin
					do b = 8'($urandom_range(255)); while (b == 8'd10);
					send_beat(b);
				end
				send_beat(8'd10);
			end
			8: send_beat(8'd10);
			default: send_text($urandom_range(1) ? "." : "..");
		endcase
		// mostly keep lexemes apart so words and numbers close cleanly
		if ($urandom_range(9) < 7) send_beat(" ");
	endtask

	task automatic run_random(input int count, input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) send_lexeme();
	endtask

	// Every operator at least once, some keywords, long words and literal forms.
	task automatic test_directed();
		send_text("+ - -> * / // % ^ ^= # |= | ? == = := ~ != << <= < >= > & .. . ");
		send_text("( ) { } [ ] , ; :: :\n");
		send_text("MUTABLE elseif procedures continue x_9\n");
		send_text("12.5 7. .5 9.x \"a\\\"b\" 'q' '\\'\n");
		send_text("a--c\n<<=::=->-\n");
		send_beat("'");
		send_beat(8'd0);
		send_beat("'");
		send_beat(" ");
	endtask

	task automatic test_idle_phases();
		run_random(4, 0, 0);
		run_random(4, 53, 0);
		run_random(4, 0, 53);
		run_random(4, 38, 38);
	endtask

	// Hold the receiver off while the sender keeps offering beats.
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 40;
		for (int i = 0; i < 6; i++) send_text("; ");
	endtask

	// The stream ends once, either cleanly or through one error case.
	task automatic test_termination();
		idle_pct = 20;
		stall_pct = 20;
		case ($urandom_range(7))
			0: send_text("\"open text");
			1: send_text("\"broken\nline");
			2: send_text("'ab'");
			3: send_text("'");
			4: send_text("! ");
			5: send_beat(8'($urandom_range(255, 128)));
			6: send_text("x = \"closed\"");
			default: send_text("tail_word");
		endcase
		send_beat(8'd0, 1'b1);
		// drop: everything after the end token is ignored
		for (int i = 0; i < 6; i++) send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_idle_phases();
		test_backpressure();
		test_termination();
		while (token_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d source bytes and %0d tokens across idle, stall,",
			bytes_sent, tokens_seen);
		$display("hold-off and end-of-text phases");
		if (mismatches == 0 && token_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d tokens missing", mismatches, token_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/stt_pkg.sv
design/stt_res_fifo.sv
design/source_text_tokenizer_core.sv
test/testbench.sv
